@@ hdl/tbt_pkg.sv @@
// Shared types, widths and constants for the two-radar triangulation block.
`default_nettype none

package tbt_pkg;

    localparam int MAX_REPORTS  = 16;
    localparam int IDX_W        = $clog2(MAX_REPORTS);
    localparam int CNT_W        = $clog2(MAX_REPORTS + 1);

    localparam int AZ_W         = 26;
    localparam int RNG_W        = 24;
    localparam int CFG_W        = 32;
    localparam int RAD_W        = 16;
    localparam int POS_W        = 32;

    localparam int IN_DATA_W    = 104;
    localparam int OUT_DATA_W   = 64;
    localparam int OUT_USER_W   = 2;

    localparam int TRIG_W       = 27;
    localparam int TRIG_FRAC    = 24;
    localparam int ANG_W        = 25;
    localparam int RED_W        = 27;
    localparam int Z_W          = 25;
    localparam int CORDIC_STEPS = 18;
    localparam int STEP_W       = 5;

    localparam int X1_W         = 28;
    localparam int DX_W         = 34;
    localparam int SQ_W         = 64;
    localparam int LIM_W        = 48;
    localparam int DET_W        = 56;
    localparam int K_W          = 60;
    localparam int KH_W         = 30;
    localparam int FM_W         = 27;
    localparam int P_W          = 88;
    localparam int Q_W          = 64;
    localparam int MUL_W        = 33;
    localparam int PROD_W       = 66;
    localparam int DCNT_W       = 6;

    localparam logic signed [RED_W-1:0] FULL_TURN    = 27'sd23592960;
    localparam logic signed [RED_W-1:0] TWO_TURNS    = 27'sd47185920;
    localparam logic signed [RED_W-1:0] NEG_TURN     = -27'sd23592960;
    localparam logic [ANG_W-1:0]        QUARTER_1    = 25'd5898240;
    localparam logic [ANG_W-1:0]        QUARTER_2    = 25'd11796480;
    localparam logic [ANG_W-1:0]        QUARTER_3    = 25'd17694720;
    localparam logic signed [TRIG_W-1:0] CORDIC_START = 27'sd10188014;
    localparam logic [RAD_W-1:0]        RADIUS_RESET = 16'd250;

    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7fffffff;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh80000000;

    typedef enum logic [1:0] {
        REG_X = 2'd0,
        REG_Y = 2'd1,
        REG_R = 2'd2
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LIM, S_LIMC, S_J1, S_C1W, S_X1M, S_Y1M, S_Y1C, S_C2W,
        S_DXM, S_DYM, S_UXM, S_UYM, S_ACC, S_CMP, S_NXI, S_Q1, S_Q1W,
        S_Q2W, S_DA, S_DB, S_DC, S_KA, S_KB, S_KC, S_FA, S_FB, S_FC,
        S_FW, S_EMIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        CS_IDLE, CS_PREP, CS_ITER, CS_DONE
    } cordic_state_t;

    typedef enum logic [1:0] {
        DV_IDLE, DV_RUN, DV_FIN, DV_DONE
    } div_state_t;

    typedef enum logic [3:0] {
        M_NONE, M_LIM, M_R1C1, M_R1S1, M_R2C2, M_R2S2, M_UX, M_UY,
        M_S2C1, M_C2S1, M_S2X, M_C2Y, M_FKLO, M_FKHI
    } mul_sel_t;

    typedef enum logic [3:0] {
        C_NONE, C_LIM, C_X1, C_Y1, C_DX, C_DY, C_SQ, C_SQADD,
        C_DETA, C_DETB, C_KA, C_KB, C_PLO, C_PHI
    } cap_sel_t;

    typedef enum logic [1:0] {
        SRC_AZ1J, SRC_AZ2I, SRC_AZ2P
    } cs_src_t;

    typedef struct packed {
        logic     in_ready;
        mul_sel_t mul;
        cap_sel_t cap;
        logic     cs_start;
        cs_src_t  cs_src;
        logic     cap_cs1;
        logic     cap_cs2;
        logic     part_init;
        logic     part_upd;
        logic     i_clr;
        logic     i_inc;
        logic     j_clr;
        logic     j_inc;
        logic     clip_init;
        logic     f_sel;
        logic     div_start;
        logic     cap_px;
        logic     cap_py;
        logic     emit;
        logic     set_end;
    } dp_cmd_t;

    typedef struct packed {
        logic cordic_done;
        logic div_done;
        logic n_zero;
        logic i_last;
        logic j_last;
        logic match;
        logic det_zero;
        logic out_free;
    } dp_stat_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic signed [Z_W-1:0] atan_val(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hdl/two_radar_bearing_triangulation_top.sv @@
// Top level of the two-radar bearing triangulation block.
//
//  channel   dir  handshake                 payload
//  in        in   in_tvalid / in_tready     tdata, tuser = has_reports, tlast = end_of_set
//  out       out  out_tvalid / out_tready   tdata, tuser = {clipped, parallel}, tlast
//  cfg       in   cfg_we (no wait)          cfg_addr, cfg_wdata
//
//  Loading takes one cycle per item. The item with tlast starts the set pass:
//  pairing, then intersection per report (shorter on a saturated quotient or
//  parallel lines), built on the iterative CORDIC and the 64-step divider, used twice.
//  No input is taken during the pass; a result waits in the output register under stall.
//  Reset is asynchronous; store contents are not cleared.
`default_nettype none

module two_radar_bearing_triangulation_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_tvalid,
    output logic                                    in_tready,
    // [25:0] first_azimuth, [49:26] first_range, [75:50] second_azimuth,
    // [99:76] second_range, [103:100] zero
    input  wire logic [tbt_pkg::IN_DATA_W-1:0]      in_tdata,
    // [0] has_reports
    input  wire logic                               in_tuser,
    input  wire logic                               in_tlast,
    output logic                                    out_tvalid,
    input  wire logic                               out_tready,
    // [31:0] pos_x, [63:32] pos_y
    output logic [tbt_pkg::OUT_DATA_W-1:0]          out_tdata,
    // [0] parallel, [1] clipped
    output logic [tbt_pkg::OUT_USER_W-1:0]          out_tuser,
    output logic                                    out_tlast,
    input  wire logic                               cfg_we,
    input  wire logic [1:0]                         cfg_addr,
    input  wire logic [tbt_pkg::CFG_W-1:0]          cfg_wdata
);
    import tbt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (in_tvalid),
        .in_tlast  (in_tlast),
        .stat      (stat),
        .cmd       (cmd)
    );

    tbt_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_tvalid  (in_tvalid),
        .in_tdata   (in_tdata),
        .in_tuser   (in_tuser),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .out_tvalid (out_tvalid),
        .out_tready (out_tready),
        .out_tdata  (out_tdata),
        .out_tuser  (out_tuser),
        .out_tlast  (out_tlast)
    );

    assign in_tready = cmd.in_ready;

endmodule

`default_nettype wire

@@ hdl/tbt_cordic.sv @@
// Iterative CORDIC unit: azimuth in 2^-16 degree to cos/sin in Q24.
`default_nettype none

module tbt_cordic (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [tbt_pkg::AZ_W-1:0]           angle,
    output logic                                    done,
    output logic signed [tbt_pkg::TRIG_W-1:0]       cos_o,
    output logic signed [tbt_pkg::TRIG_W-1:0]       sin_o
);
    import tbt_pkg::*;

    cordic_state_t              state_reg, state_next;
    logic [ANG_W-1:0]           ang_reg, ang_next;
    logic [1:0]                 quad_reg, quad_next;
    logic signed [TRIG_W-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]      z_reg, z_next;
    logic [STEP_W-1:0]          step_reg, step_next;

    logic signed [RED_W-1:0]    a_ext, red;
    logic signed [TRIG_W-1:0]   xsh, ysh;
    logic signed [Z_W-1:0]      at;
    logic [ANG_W-1:0]           zp;

    // reduce into [0, full turn)
    always_comb
    begin
        a_ext = RED_W'(signed'(angle));
        if (a_ext >= FULL_TURN)
            red = a_ext - FULL_TURN;
        else if (a_ext >= 0)
            red = a_ext;
        else if (a_ext >= NEG_TURN)
            red = a_ext + FULL_TURN;
        else
            red = a_ext + TWO_TURNS;
    end

    assign xsh = x_reg >>> step_reg;
    assign ysh = y_reg >>> step_reg;
    assign at  = atan_val(step_reg);

    always_comb
    begin
        state_next = state_reg;
        ang_next   = ang_reg;
        quad_next  = quad_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        step_next  = step_reg;
        zp         = '0;
        if (start)
        begin
            ang_next   = red[ANG_W-1:0];
            state_next = CS_PREP;
        end
        else
        begin
            unique case (state_reg)
                CS_IDLE: ;
                CS_PREP:
                begin
                    if (ang_reg >= QUARTER_3)
                    begin
                        quad_next = 2'd3;
                        zp        = ang_reg - QUARTER_3;
                    end
                    else if (ang_reg >= QUARTER_2)
                    begin
                        quad_next = 2'd2;
                        zp        = ang_reg - QUARTER_2;
                    end
                    else if (ang_reg >= QUARTER_1)
                    begin
                        quad_next = 2'd1;
                        zp        = ang_reg - QUARTER_1;
                    end
                    else
                    begin
                        quad_next = 2'd0;
                        zp        = ang_reg;
                    end
                    z_next     = signed'(zp);
                    x_next     = CORDIC_START;
                    y_next     = '0;
                    step_next  = '0;
                    state_next = CS_ITER;
                end
                CS_ITER:
                begin
                    if (z_reg >= 0)
                    begin
                        x_next = x_reg - ysh;
                        y_next = y_reg + xsh;
                        z_next = z_reg - at;
                    end
                    else
                    begin
                        x_next = x_reg + ysh;
                        y_next = y_reg - xsh;
                        z_next = z_reg + at;
                    end
                    step_next = step_reg + 1'b1;
                    if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                        state_next = CS_DONE;
                end
                CS_DONE: state_next = CS_IDLE;
                default: state_next = CS_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        ang_reg  <= ang_next;
        quad_reg <= quad_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        step_reg <= step_next;
    end

    assign done = (state_reg == CS_DONE);

    // exact quadrant rotation
    always_comb
    begin
        case (quad_reg)
            2'd0:    begin cos_o = x_reg;  sin_o = y_reg;  end
            2'd1:    begin cos_o = -y_reg; sin_o = x_reg;  end
            2'd2:    begin cos_o = -x_reg; sin_o = -y_reg; end
            default: begin cos_o = y_reg;  sin_o = -x_reg; end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/tbt_div.sv @@
// Restoring divider: saturated trunc(num/den) with sign applied, one bit a cycle.
`default_nettype none

module tbt_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [tbt_pkg::P_W-1:0]        num,
    input  wire logic [tbt_pkg::DET_W-1:0]      den,
    input  wire logic                           neg,
    output logic                                done,
    output logic signed [tbt_pkg::POS_W-1:0]    res,
    output logic                                sat
);
    import tbt_pkg::*;

    div_state_t                 state_reg, state_next;
    logic [DET_W-1:0]           rem_reg, rem_next, den_reg, den_next;
    logic [Q_W-1:0]             lo_reg, lo_next, q_reg, q_next;
    logic [DCNT_W-1:0]          cnt_reg, cnt_next;
    logic                       neg_reg, neg_next;
    logic signed [POS_W-1:0]    res_reg, res_next;
    logic                       sat_reg, sat_next;
    logic [DET_W:0]             sh, diff;
    logic                       ge;

    assign sh   = {rem_reg, lo_reg[Q_W-1]};
    assign ge   = (sh >= {1'b0, den_reg});
    assign diff = sh - {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        lo_next    = lo_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        sat_next   = sat_reg;
        if (start)
        begin
            den_next = den;
            neg_next = neg;
            rem_next = DET_W'(num[P_W-1:Q_W]);
            lo_next  = num[Q_W-1:0];
            q_next   = '0;
            cnt_next = '0;
            sat_next = 1'b0;
            if (DET_W'(num[P_W-1:Q_W]) >= den)
            begin
                sat_next   = 1'b1;
                res_next   = neg ? POS_MIN : POS_MAX;
                state_next = DV_DONE;
            end
            else
                state_next = DV_RUN;
        end
        else
        begin
            unique case (state_reg)
                DV_IDLE: ;
                DV_RUN:
                begin
                    rem_next = ge ? diff[DET_W-1:0] : sh[DET_W-1:0];
                    lo_next  = {lo_reg[Q_W-2:0], 1'b0};
                    q_next   = {q_reg[Q_W-2:0], ge};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == {DCNT_W{1'b1}})
                        state_next = DV_FIN;
                end
                DV_FIN:
                begin
                    if (neg_reg)
                    begin
                        if (q_reg > Q_W'(64'h8000_0000))
                        begin
                            sat_next = 1'b1;
                            res_next = POS_MIN;
                        end
                        else
                            res_next = -signed'(q_reg[POS_W-1:0]);
                    end
                    else
                    begin
                        if (q_reg > Q_W'(64'h7fff_ffff))
                        begin
                            sat_next = 1'b1;
                            res_next = POS_MAX;
                        end
                        else
                            res_next = signed'(q_reg[POS_W-1:0]);
                    end
                    state_next = DV_DONE;
                end
                DV_DONE: state_next = DV_IDLE;
                default: state_next = DV_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= DV_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
        sat_reg <= sat_next;
    end

    assign done = (state_reg == DV_DONE);
    assign res  = res_reg;
    assign sat  = sat_reg;

endmodule

`default_nettype wire

@@ hdl/tbt_dpath.sv @@
// Datapath: report stores, config registers, shared multiplier, CORDIC, divider, output stage.
`default_nettype none

module tbt_dpath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire tbt_pkg::dp_cmd_t                   cmd,
    output tbt_pkg::dp_stat_t                       stat,
    input  wire logic                               in_tvalid,
    input  wire logic [tbt_pkg::IN_DATA_W-1:0]      in_tdata,
    input  wire logic                               in_tuser,
    input  wire logic                               cfg_we,
    input  wire logic [1:0]                         cfg_addr,
    input  wire logic [tbt_pkg::CFG_W-1:0]          cfg_wdata,
    output logic                                    out_tvalid,
    input  wire logic                               out_tready,
    output logic [tbt_pkg::OUT_DATA_W-1:0]          out_tdata,
    output logic [tbt_pkg::OUT_USER_W-1:0]          out_tuser,
    output logic                                    out_tlast
);
    import tbt_pkg::*;

    logic [AZ_W-1:0]            az1_mem [MAX_REPORTS];
    logic [RNG_W-1:0]           r1_mem  [MAX_REPORTS];
    logic [AZ_W-1:0]            az2_mem [MAX_REPORTS];
    logic [RNG_W-1:0]           r2_mem  [MAX_REPORTS];
    logic [IDX_W-1:0]           part_mem[MAX_REPORTS];

    logic [CNT_W-1:0]           cnt_reg;
    logic                       ovf_reg;
    logic [IDX_W-1:0]           i_reg, j_reg;
    logic signed [CFG_W-1:0]    xoff_reg, yoff_reg;
    logic [RAD_W-1:0]           rad_reg;

    logic signed [PROD_W-1:0]   prod_reg;
    logic [LIM_W-1:0]           lim_reg;
    logic signed [TRIG_W-1:0]   c1_reg, s1_reg, c2_reg, s2_reg;
    logic signed [X1_W-1:0]     x1_reg, y1_reg;
    logic [CFG_W-1:0]           ux_reg, uy_reg;
    logic [SQ_W-1:0]            acc_reg;
    logic [K_W-1:0]             t_reg;
    logic signed [DET_W-1:0]    det_reg;
    logic signed [K_W-1:0]      k_reg;
    logic [P_W-1:0]             p_reg;
    logic signed [POS_W-1:0]    px_reg, py_reg;
    logic                       clip_reg;

    logic                       ov_reg;
    logic [OUT_DATA_W-1:0]      od_reg;
    logic [OUT_USER_W-1:0]      ou_reg;
    logic                       ol_reg;

    logic                       in_fire, store_ok, out_free;
    logic [IDX_W-1:0]           wr_idx;
    logic signed [MUL_W-1:0]    ma, mb;
    logic signed [DX_W-1:0]     dsum, dmag;
    logic signed [TRIG_W-1:0]   fval;
    logic [FM_W-1:0]            fmag;
    logic [K_W-1:0]             kmag;
    logic [DET_W-1:0]           dmag_det;
    logic [AZ_W-1:0]            cs_angle;
    logic                       cs_done, dv_done, dv_sat;
    logic signed [TRIG_W-1:0]   cs_cos, cs_sin;
    logic signed [POS_W-1:0]    dv_res;
    logic                       neg;

    assign in_fire  = in_tvalid & cmd.in_ready;
    assign store_ok = (cnt_reg < CNT_W'(MAX_REPORTS));
    assign wr_idx   = cnt_reg[IDX_W-1:0];
    assign out_free = !ov_reg || out_tready;

    // report stores
    always_ff @(posedge clk)
    begin
        if (in_fire && in_tuser && store_ok)
        begin
            az1_mem[wr_idx] <= in_tdata[25:0];
            r1_mem[wr_idx]  <= in_tdata[49:26];
            az2_mem[wr_idx] <= in_tdata[75:50];
            r2_mem[wr_idx]  <= in_tdata[99:76];
        end
        if (cmd.part_init)
            part_mem[j_reg] <= j_reg;
        else if (cmd.part_upd && stat.match)
            part_mem[j_reg] <= i_reg;
    end

    // control and config state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            i_reg    <= '0;
            j_reg    <= '0;
            xoff_reg <= '0;
            yoff_reg <= '0;
            rad_reg  <= RADIUS_RESET;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.set_end)
            begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else if (in_fire && in_tuser)
            begin
                if (store_ok)
                    cnt_reg <= cnt_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.i_clr)
                i_reg <= '0;
            else if (cmd.i_inc)
                i_reg <= i_reg + 1'b1;
            if (cmd.j_clr)
                j_reg <= '0;
            else if (cmd.j_inc)
                j_reg <= j_reg + 1'b1;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_X:   xoff_reg <= signed'(cfg_wdata);
                    REG_Y:   yoff_reg <= signed'(cfg_wdata);
                    REG_R:   rad_reg  <= cfg_wdata[RAD_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.emit)
                ov_reg <= 1'b1;
            else if (out_tready)
                ov_reg <= 1'b0;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.mul)
            M_LIM:
            begin
                ma = MUL_W'({rad_reg, 8'b0});
                mb = MUL_W'({rad_reg, 8'b0});
            end
            M_R1C1: begin ma = MUL_W'(r1_mem[j_reg]); mb = MUL_W'(c1_reg); end
            M_R1S1: begin ma = MUL_W'(r1_mem[j_reg]); mb = MUL_W'(s1_reg); end
            M_R2C2: begin ma = MUL_W'(r2_mem[i_reg]); mb = MUL_W'(c2_reg); end
            M_R2S2: begin ma = MUL_W'(r2_mem[i_reg]); mb = MUL_W'(s2_reg); end
            M_UX:   begin ma = MUL_W'(ux_reg);        mb = MUL_W'(ux_reg); end
            M_UY:   begin ma = MUL_W'(uy_reg);        mb = MUL_W'(uy_reg); end
            M_S2C1: begin ma = MUL_W'(s2_reg);        mb = MUL_W'(c1_reg); end
            M_C2S1: begin ma = MUL_W'(c2_reg);        mb = MUL_W'(s1_reg); end
            M_S2X:  begin ma = MUL_W'(s2_reg);        mb = MUL_W'(xoff_reg); end
            M_C2Y:  begin ma = MUL_W'(c2_reg);        mb = MUL_W'(yoff_reg); end
            M_FKLO: begin ma = MUL_W'(fmag); mb = MUL_W'(kmag[KH_W-1:0]); end
            M_FKHI: begin ma = MUL_W'(fmag); mb = MUL_W'(kmag[K_W-1:KH_W]); end
            default: ;
        endcase
    end

    assign dsum = DX_W'(signed'(prod_reg[X1_W+TRIG_FRAC-1:TRIG_FRAC]));
    assign fval = cmd.f_sel ? s1_reg : c1_reg;
    assign fmag = fval[TRIG_W-1] ? FM_W'(-fval) : FM_W'(fval);
    assign kmag = k_reg[K_W-1] ? K_W'(-k_reg) : K_W'(k_reg);
    assign dmag_det = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
    assign neg  = fval[TRIG_W-1] ^ k_reg[K_W-1] ^ det_reg[DET_W-1];

    always_comb
    begin
        case (cmd.cap)
            C_DX:    dmag = dsum + DX_W'(xoff_reg) - DX_W'(x1_reg);
            default: dmag = dsum + DX_W'(yoff_reg) - DX_W'(y1_reg);
        endcase
        if (dmag[DX_W-1])
            dmag = -dmag;
    end

    always_comb
    begin
        case (cmd.cs_src)
            SRC_AZ2I: cs_angle = az2_mem[i_reg];
            SRC_AZ2P: cs_angle = az2_mem[part_mem[j_reg]];
            default:  cs_angle = az1_mem[j_reg];
        endcase
    end

    tbt_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.cs_start),
        .angle (cs_angle),
        .done  (cs_done),
        .cos_o (cs_cos),
        .sin_o (cs_sin)
    );

    tbt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (p_reg),
        .den   (dmag_det),
        .neg   (neg),
        .done  (dv_done),
        .res   (dv_res),
        .sat   (dv_sat)
    );

    // arithmetic payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        if (cmd.cap_cs1)
        begin
            c1_reg <= cs_cos;
            s1_reg <= cs_sin;
        end
        if (cmd.cap_cs2)
        begin
            c2_reg <= cs_cos;
            s2_reg <= cs_sin;
        end
        case (cmd.cap)
            C_LIM:   lim_reg <= prod_reg[LIM_W-1:0];
            C_X1:    x1_reg  <= signed'(prod_reg[X1_W+TRIG_FRAC-1:TRIG_FRAC]);
            C_Y1:    y1_reg  <= signed'(prod_reg[X1_W+TRIG_FRAC-1:TRIG_FRAC]);
            C_DX:    ux_reg  <= dmag[CFG_W-1:0];
            C_DY:    uy_reg  <= dmag[CFG_W-1:0];
            C_SQ:    acc_reg <= prod_reg[SQ_W-1:0];
            C_SQADD: acc_reg <= acc_reg + prod_reg[SQ_W-1:0];
            C_DETA:  t_reg   <= prod_reg[K_W-1:0];
            C_DETB:  det_reg <= signed'(t_reg[DET_W-1:0] - prod_reg[DET_W-1:0]);
            C_KA:    t_reg   <= prod_reg[K_W-1:0];
            C_KB:    k_reg   <= signed'(t_reg - prod_reg[K_W-1:0]);
            C_PLO:   p_reg   <= P_W'(prod_reg[PROD_W-1:0]);
            C_PHI:   p_reg   <= p_reg + {prod_reg[P_W-KH_W-1:0], {KH_W{1'b0}}};
            default: ;
        endcase
        if (cmd.clip_init)
            clip_reg <= ovf_reg;
        else if ((cmd.cap_px || cmd.cap_py) && dv_sat)
            clip_reg <= 1'b1;
        if (cmd.cap_px)
            px_reg <= dv_res;
        if (cmd.cap_py)
            py_reg <= dv_res;
        if (cmd.emit)
        begin
            od_reg <= stat.det_zero ? '0 : {py_reg, px_reg};
            ou_reg <= {clip_reg, stat.det_zero};
            ol_reg <= stat.j_last;
        end
    end

    assign stat.cordic_done = cs_done;
    assign stat.div_done    = dv_done;
    assign stat.n_zero      = (cnt_reg == '0);
    assign stat.i_last      = (CNT_W'(i_reg) + 1'b1 == cnt_reg);
    assign stat.j_last      = (CNT_W'(j_reg) + 1'b1 == cnt_reg);
    assign stat.match       = (acc_reg < SQ_W'(lim_reg));
    assign stat.det_zero    = (det_reg == '0);
    assign stat.out_free    = out_free;

    assign out_tvalid = ov_reg;
    assign out_tdata  = od_reg;
    assign out_tuser  = ou_reg;
    assign out_tlast  = ol_reg;

endmodule

`default_nettype wire

@@ hdl/tbt_ctrl.sv @@
// Controller: sequences loading, pairing pass and intersection pass.
`default_nettype none

module tbt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_tvalid,
    input  wire logic               in_tlast,
    input  wire tbt_pkg::dp_stat_t  stat,
    output tbt_pkg::dp_cmd_t        cmd
);
    import tbt_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        f_reg, f_next;
    logic        div_go_reg;

    always_comb
    begin
        state_next = state_reg;
        f_next     = f_reg;
        unique case (state_reg)
            S_IDLE:  if (in_tvalid && in_tlast) state_next = S_LIM;
            S_LIM:   state_next = stat.n_zero ? S_IDLE : S_LIMC;
            S_LIMC:  state_next = S_J1;
            S_J1:    state_next = S_C1W;
            S_C1W:   if (stat.cordic_done) state_next = S_X1M;
            S_X1M:   state_next = S_Y1M;
            S_Y1M:   state_next = S_Y1C;
            S_Y1C:   state_next = S_C2W;
            S_C2W:   if (stat.cordic_done) state_next = S_DXM;
            S_DXM:   state_next = S_DYM;
            S_DYM:   state_next = S_UXM;
            S_UXM:   state_next = S_UYM;
            S_UYM:   state_next = S_ACC;
            S_ACC:   state_next = S_CMP;
            S_CMP:
            begin
                if (!stat.i_last)
                    state_next = S_NXI;
                else if (!stat.j_last)
                    state_next = S_J1;
                else
                    state_next = S_Q1;
            end
            S_NXI:   state_next = S_C2W;
            S_Q1:    state_next = S_Q1W;
            S_Q1W:   if (stat.cordic_done) state_next = S_Q2W;
            S_Q2W:   if (stat.cordic_done) state_next = S_DA;
            S_DA:    state_next = S_DB;
            S_DB:    state_next = S_DC;
            S_DC:    state_next = S_KA;
            S_KA:    state_next = stat.det_zero ? S_EMIT : S_KB;
            S_KB:    state_next = S_KC;
            S_KC:
            begin
                f_next     = 1'b0;
                state_next = S_FA;
            end
            S_FA:    state_next = S_FB;
            S_FB:    state_next = S_FC;
            S_FC:    state_next = S_FW;
            S_FW:
            begin
                if (stat.div_done)
                begin
                    if (!f_reg)
                    begin
                        f_next     = 1'b1;
                        state_next = S_FA;
                    end
                    else
                        state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                    state_next = stat.j_last ? S_IDLE : S_Q1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.mul       = M_NONE;
        cmd.cap       = C_NONE;
        cmd.cs_src    = SRC_AZ1J;
        cmd.f_sel     = f_reg;
        cmd.div_start = div_go_reg;
        unique case (state_reg)
            S_IDLE:  cmd.in_ready = 1'b1;
            S_LIM:
            begin
                cmd.mul     = M_LIM;
                cmd.j_clr   = 1'b1;
                cmd.set_end = stat.n_zero;
            end
            S_LIMC:  cmd.cap = C_LIM;
            S_J1:
            begin
                cmd.cs_start  = 1'b1;
                cmd.part_init = 1'b1;
                cmd.i_clr     = 1'b1;
            end
            S_C1W:   cmd.cap_cs1 = stat.cordic_done;
            S_X1M:   cmd.mul = M_R1C1;
            S_Y1M:
            begin
                cmd.cap = C_X1;
                cmd.mul = M_R1S1;
            end
            S_Y1C:
            begin
                cmd.cap      = C_Y1;
                cmd.cs_start = 1'b1;
                cmd.cs_src   = SRC_AZ2I;
            end
            S_C2W:   cmd.cap_cs2 = stat.cordic_done;
            S_DXM:   cmd.mul = M_R2C2;
            S_DYM:
            begin
                cmd.cap = C_DX;
                cmd.mul = M_R2S2;
            end
            S_UXM:
            begin
                cmd.cap = C_DY;
                cmd.mul = M_UX;
            end
            S_UYM:
            begin
                cmd.cap = C_SQ;
                cmd.mul = M_UY;
            end
            S_ACC:   cmd.cap = C_SQADD;
            S_CMP:
            begin
                cmd.part_upd = 1'b1;
                if (!stat.i_last)
                    cmd.i_inc = 1'b1;
                else if (!stat.j_last)
                    cmd.j_inc = 1'b1;
                else
                    cmd.j_clr = 1'b1;
            end
            S_NXI:
            begin
                cmd.cs_start = 1'b1;
                cmd.cs_src   = SRC_AZ2I;
            end
            S_Q1:
            begin
                cmd.cs_start  = 1'b1;
                cmd.clip_init = 1'b1;
            end
            S_Q1W:
            begin
                cmd.cap_cs1  = stat.cordic_done;
                cmd.cs_start = stat.cordic_done;
                cmd.cs_src   = SRC_AZ2P;
            end
            S_Q2W:   cmd.cap_cs2 = stat.cordic_done;
            S_DA:    cmd.mul = M_S2C1;
            S_DB:
            begin
                cmd.cap = C_DETA;
                cmd.mul = M_C2S1;
            end
            S_DC:    cmd.cap = C_DETB;
            S_KA:    cmd.mul = M_S2X;
            S_KB:
            begin
                cmd.cap = C_KA;
                cmd.mul = M_C2Y;
            end
            S_KC:    cmd.cap = C_KB;
            S_FA:    cmd.mul = M_FKLO;
            S_FB:
            begin
                cmd.cap = C_PLO;
                cmd.mul = M_FKHI;
            end
            S_FC:
            begin
                cmd.cap = C_PHI;
            end
            S_FW:
            begin
                cmd.cap_px = stat.div_done && !f_reg;
                cmd.cap_py = stat.div_done && f_reg;
            end
            S_EMIT:
            begin
                cmd.emit = stat.out_free;
                if (stat.out_free)
                begin
                    cmd.set_end = stat.j_last;
                    cmd.j_inc   = !stat.j_last;
                end
            end
            default: ;
        endcase
    end

    // divider starts in the cycle after the product is complete
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            f_reg      <= 1'b0;
            div_go_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            f_reg      <= f_next;
            div_go_reg <= (state_reg == S_FC);
        end
    end

endmodule

`default_nettype wire
